// File: design/pcgd_pkg.sv
// Shared widths, reset value and register map of the pulley contact gap detector.
`default_nettype none
package pcgd_pkg;

	localparam int SQ_W      = 66;  // squared distance, Q34.32 magnitude
	localparam int RT_W      = 34;  // integer square root of SQ_W bits
	localparam int REM_W     = 35;  // root remainder, at most twice the root
	localparam int NUM_W     = 48;  // divider numerator, |offset| * 2^14 + d/2
	localparam int Q_W       = 15;  // unit component magnitude, up to 16384
	localparam int NORM_FRAC = 14;  // fraction bits of a Q2.14 component
	localparam int ADDR_W    = 5;

	typedef enum logic [2:0] {
		REG_CENTER_X  = 3'd0,
		REG_CENTER_Y  = 3'd1,
		REG_CENTER_Z  = 3'd2,
		REG_RADIUS    = 3'd3,
		REG_TOLERANCE = 3'd4,
		REG_TAG       = 3'd5,
		REG_FRICTION  = 3'd6,
		REG_NONE      = 3'd7
	} reg_idx_t;

	localparam logic [30:0] RADIUS_RESET = 31'd65536;

endpackage
`default_nettype wire

// File: design/pcgd_sqrt.sv
// Pipelined integer square root, one root bit per stage, with a side tag.
`default_nettype none
module pcgd_sqrt
	import pcgd_pkg::*;
#(
	parameter int TAG_W = 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [SQ_W-1:0]    in_sq,
	input  wire logic [TAG_W-1:0]   in_tag,
	output logic                    out_valid,
	output logic [RT_W-1:0]         out_root,
	output logic [TAG_W-1:0]        out_tag
);

	localparam int STEPS = SQ_W / 2;

	logic                 v_s    [0:STEPS];
	logic [SQ_W-1:0]      sq_s   [0:STEPS];
	logic [RT_W-1:0]      root_s [0:STEPS];
	logic [REM_W-1:0]     rem_s  [0:STEPS];
	logic [TAG_W-1:0]     tag_s  [0:STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sq_s[0]   <= in_sq;
		root_s[0] <= '0;
		rem_s[0]  <= '0;
		tag_s[0]  <= in_tag;
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic [REM_W+1:0] cur;
		logic [REM_W+1:0] trial;
		logic             take;

		// Bring down the next two bits and try a one in the next root place.
		assign cur   = {rem_s[i], sq_s[i][SQ_W-1 -: 2]};
		assign trial = {(REM_W+2-RT_W-2)'(0), root_s[i], 2'b01};
		assign take  = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			sq_s[i+1]   <= {sq_s[i][SQ_W-3:0], 2'b00};
			root_s[i+1] <= {root_s[i][RT_W-2:0], take};
			rem_s[i+1]  <= take ? REM_W'(cur - trial) : cur[REM_W-1:0];
			tag_s[i+1]  <= tag_s[i];
		end
	end

	assign out_valid = v_s[STEPS];
	assign out_root  = root_s[STEPS];
	assign out_tag   = tag_s[STEPS];

endmodule
`default_nettype wire

// File: design/pcgd_div2.sv
// Pipelined twin restoring divider sharing one divisor, one quotient bit per stage.
`default_nettype none
module pcgd_div2
	import pcgd_pkg::*;
#(
	parameter int TAG_W = 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [NUM_W-1:0]   in_num_a,
	input  wire logic [NUM_W-1:0]   in_num_b,
	input  wire logic [RT_W-1:0]    in_den,
	input  wire logic [TAG_W-1:0]   in_tag,
	output logic                    out_valid,
	output logic [Q_W-1:0]          out_q_a,
	output logic [Q_W-1:0]          out_q_b,
	output logic [TAG_W-1:0]        out_tag
);

	logic               v_s   [0:Q_W];
	logic [NUM_W-1:0]   ra_s  [0:Q_W];
	logic [NUM_W-1:0]   rb_s  [0:Q_W];
	logic [Q_W-1:0]     qa_s  [0:Q_W];
	logic [Q_W-1:0]     qb_s  [0:Q_W];
	logic [RT_W-1:0]    den_s [0:Q_W];
	logic [TAG_W-1:0]   tag_s [0:Q_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		ra_s[0]  <= in_num_a;
		rb_s[0]  <= in_num_b;
		qa_s[0]  <= '0;
		qb_s[0]  <= '0;
		den_s[0] <= in_den;
		tag_s[0] <= in_tag;
	end

	for (genvar i = 0; i < Q_W; i++) begin : g_step
		logic [NUM_W-1:0] dsh;
		logic             ta;
		logic             tb;

		assign dsh = NUM_W'(den_s[i]) << (Q_W - 1 - i);
		assign ta  = (ra_s[i] >= dsh);
		assign tb  = (rb_s[i] >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			ra_s[i+1]  <= ta ? (ra_s[i] - dsh) : ra_s[i];
			rb_s[i+1]  <= tb ? (rb_s[i] - dsh) : rb_s[i];
			qa_s[i+1]  <= {qa_s[i][Q_W-2:0], ta};
			qb_s[i+1]  <= {qb_s[i][Q_W-2:0], tb};
			den_s[i+1] <= den_s[i];
			tag_s[i+1] <= tag_s[i];
		end
	end

	assign out_valid = v_s[Q_W];
	assign out_q_a   = qa_s[Q_W];
	assign out_q_b   = qb_s[Q_W];
	assign out_tag   = tag_s[Q_W];

endmodule
`default_nettype wire

// File: design/pulley_contact_gap_detector_top.sv
// Top level of the pulley contact gap detector: registers, pipeline and result port.
`default_nettype none
// Tests one cable node (point_x, point_y) per cycle against the pulley circle
// held in the registers. busy is always low, so an item is taken on every cycle
// that start is high; its result is shown with done for one cycle only, since
// the receiver cannot stall. Each item passes through the offset, magnitude,
// square and sum registers, the square root pipeline (one root bit per stage),
// the gap register, the twin divider for the unit normal (one quotient bit per
// stage) and the output register. Results leave in item order.
// Change registers only while no item is in flight: items in the pipe read the
// live center z, tag, friction, radius and tolerance at their late stages.
// Register map (byte address): 0x00 center_x, 0x04 center_y, 0x08 center_z,
// 0x0C pulley_radius, 0x10 gap_tolerance, 0x14 contact_tag, 0x18 friction_coeff.
module pulley_contact_gap_detector_top
	import pcgd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// item port
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic signed [31:0]   point_x,
	input  wire logic signed [31:0]   point_y,
	// result port
	output logic                      done,
	output logic                      in_contact,
	output logic signed [31:0]        gap,
	output logic signed [15:0]        normal_x,
	output logic signed [15:0]        normal_y,
	output logic signed [15:0]        tangent_x,
	output logic signed [15:0]        tangent_y,
	output logic [15:0]               active_tag,
	output logic [15:0]               active_friction,
	output logic                      lock_z,
	output logic signed [31:0]        lock_z_value,
	// register port
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_W-1:0]    paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	localparam int STAG_W = 2 + 2 * 33;
	localparam int DTAG_W = 1 + 32 + 2 + 1;

	// ---------------- registers ----------------
	logic [31:0] center_x_q;
	logic [31:0] center_y_q;
	logic [31:0] center_z_q;
	logic [30:0] radius_q;
	logic [31:0] tol_q;
	logic [15:0] tag_q;
	logic [15:0] fric_q;
	reg_idx_t    widx;
	logic        wr_en;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign widx   = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			radius_q   <= RADIUS_RESET;
			tol_q      <= '0;
			tag_q      <= '0;
			fric_q     <= '0;
		end else if (wr_en) begin
			case (widx)
				REG_CENTER_X:  center_x_q <= pwdata;
				REG_CENTER_Y:  center_y_q <= pwdata;
				REG_CENTER_Z:  center_z_q <= pwdata;
				REG_RADIUS:    radius_q   <= pwdata[30:0];
				REG_TOLERANCE: tol_q      <= pwdata;
				REG_TAG:       tag_q      <= pwdata[15:0];
				REG_FRICTION:  fric_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (widx)
			REG_CENTER_X:  prdata = center_x_q;
			REG_CENTER_Y:  prdata = center_y_q;
			REG_CENTER_Z:  prdata = center_z_q;
			REG_RADIUS:    prdata = {1'b0, radius_q};
			REG_TOLERANCE: prdata = tol_q;
			REG_TAG:       prdata = {16'd0, tag_q};
			REG_FRICTION:  prdata = {16'd0, fric_q};
			default:       prdata = '0;
		endcase
	end

	// ---------------- stage 1: offsets from the center ----------------
	logic              v_s1;
	logic [32:0]       dx_s1;
	logic [32:0]       dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= {point_x[31], point_x} - {center_x_q[31], center_x_q};
		dy_s1 <= {point_y[31], point_y} - {center_y_q[31], center_y_q};
	end

	// ---------------- stage 2: magnitudes and signs ----------------
	logic        v_s2;
	logic [32:0] ax_s2;
	logic [32:0] ay_s2;
	logic        sx_s2;
	logic        sy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ax_s2 <= dx_s1[32] ? (33'd0 - dx_s1) : dx_s1;
		ay_s2 <= dy_s1[32] ? (33'd0 - dy_s1) : dy_s1;
		sx_s2 <= dx_s1[32];
		sy_s2 <= dy_s1[32];
	end

	// ---------------- stage 3: squares ----------------
	logic            v_s3;
	logic [SQ_W-1:0] qx_s3;
	logic [SQ_W-1:0] qy_s3;
	logic [32:0]     ax_s3;
	logic [32:0]     ay_s3;
	logic            sx_s3;
	logic            sy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		qx_s3 <= SQ_W'(ax_s2) * SQ_W'(ax_s2);
		qy_s3 <= SQ_W'(ay_s2) * SQ_W'(ay_s2);
		ax_s3 <= ax_s2;
		ay_s3 <= ay_s2;
		sx_s3 <= sx_s2;
		sy_s3 <= sy_s2;
	end

	// ---------------- stage 4: squared distance ----------------
	logic              v_s4;
	logic [SQ_W-1:0]   sum_s4;
	logic [STAG_W-1:0] stag_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		sum_s4  <= qx_s3 + qy_s3;
		stag_s4 <= {sx_s3, sy_s3, ax_s3, ay_s3};
	end

	// ---------------- square root pipeline ----------------
	logic              rv;
	logic [RT_W-1:0]   root;
	logic [STAG_W-1:0] rtag;

	pcgd_sqrt #(.TAG_W(STAG_W)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_sq     (sum_s4),
		.in_tag    (stag_s4),
		.out_valid (rv),
		.out_root  (root),
		.out_tag   (rtag)
	);

	// ---------------- gap stage: contact test and divider operands ----------------
	logic               r_sx;
	logic               r_sy;
	logic [32:0]        r_ax;
	logic [32:0]        r_ay;
	logic signed [34:0] gap_raw;
	logic signed [34:0] tol_ext;
	logic [31:0]        gap_sat;

	assign {r_sx, r_sy, r_ax, r_ay} = rtag;
	assign gap_raw = $signed({1'b0, root}) - $signed({4'd0, radius_q});
	assign tol_ext = $signed({{3{tol_q[31]}}, tol_q});
	// Hold the positive side at the largest int32; the negative side cannot overflow.
	assign gap_sat = (!gap_raw[34] && (gap_raw[33:31] != 3'd0)) ? 32'h7FFF_FFFF
	                                                               : gap_raw[31:0];

	logic              v_s5;
	logic [NUM_W-1:0]  nx_s5;
	logic [NUM_W-1:0]  ny_s5;
	logic [RT_W-1:0]   d_s5;
	logic [DTAG_W-1:0] dtag_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= rv;
		end
	end

	always_ff @(posedge clk) begin
		// Round to nearest: add half the divisor before dividing.
		nx_s5   <= (NUM_W'(r_ax) << NORM_FRAC) + NUM_W'(root >> 1);
		ny_s5   <= (NUM_W'(r_ay) << NORM_FRAC) + NUM_W'(root >> 1);
		d_s5    <= root;
		dtag_s5 <= {(gap_raw <= tol_ext), gap_sat, r_sx, r_sy, (root == '0)};
	end

	// ---------------- normal divider pipeline ----------------
	logic              dv;
	logic [Q_W-1:0]    qx;
	logic [Q_W-1:0]    qy;
	logic [DTAG_W-1:0] dtag;

	pcgd_div2 #(.TAG_W(DTAG_W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.in_num_a  (nx_s5),
		.in_num_b  (ny_s5),
		.in_den    (d_s5),
		.in_tag    (dtag_s5),
		.out_valid (dv),
		.out_q_a   (qx),
		.out_q_b   (qy),
		.out_tag   (dtag)
	);

	// ---------------- output stage ----------------
	logic        d_hit;
	logic [31:0] d_gap;
	logic        d_sx;
	logic        d_sy;
	logic        d_zero;
	logic [15:0] mx;
	logic [15:0] my;
	logic [15:0] nx;
	logic [15:0] ny;

	assign {d_hit, d_gap, d_sx, d_sy, d_zero} = dtag;
	assign mx = d_zero ? 16'd0 : {1'b0, qx};
	assign my = d_zero ? 16'd0 : {1'b0, qy};
	assign nx = d_sx ? (16'd0 - mx) : mx;
	assign ny = d_sy ? (16'd0 - my) : my;

	logic        done_s6;
	logic        hit_s6;
	logic [31:0] gap_s6;
	logic [15:0] nx_s6;
	logic [15:0] ny_s6;
	logic [15:0] tag_s6;
	logic [15:0] fric_s6;
	logic [31:0] z_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s6 <= 1'b0;
		end else begin
			done_s6 <= dv;
		end
	end

	// Drop every field to zero when the node is clear of the pulley.
	always_ff @(posedge clk) begin
		hit_s6  <= d_hit;
		gap_s6  <= d_hit ? d_gap : 32'd0;
		nx_s6   <= d_hit ? nx : 16'd0;
		ny_s6   <= d_hit ? ny : 16'd0;
		tag_s6  <= d_hit ? tag_q : 16'd0;
		fric_s6 <= d_hit ? fric_q : 16'd0;
		z_s6    <= d_hit ? center_z_q : 32'd0;
	end

	assign done            = done_s6;
	assign in_contact      = hit_s6;
	assign gap             = gap_s6;
	assign normal_x        = nx_s6;
	assign normal_y        = ny_s6;
	assign tangent_x       = 16'd0 - ny_s6;
	assign tangent_y       = nx_s6;
	assign active_tag      = tag_s6;
	assign active_friction = fric_s6;
	assign lock_z          = hit_s6;
	assign lock_z_value    = z_s6;

`ifndef NO_ASSERTIONS
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !in_contact) |-> (gap == 32'd0 && normal_x == 16'd0 &&
		normal_y == 16'd0 && active_tag == 16'd0 && lock_z_value == 32'd0))
		else $error("fields not cleared without contact");

	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (normal_x <= 16'sd16384 && normal_x >= -16'sd16384 &&
		normal_y <= 16'sd16384 && normal_y >= -16'sd16384))
		else $error("normal component out of unit range");

	a_tangent: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (tangent_y == normal_x && lock_z == in_contact))
		else $error("tangent or lock flag inconsistent");
`endif

endmodule
`default_nettype wire
